// ----- rtl/src_pkg.sv -----
`timescale 1ns / 1ps

package src_pkg;

  // field widths
  localparam int unsigned MW = 2;
  localparam int unsigned XW = 16;
  localparam int unsigned YW = 32;
  localparam int unsigned QW = 17;

  // internal arithmetic: value width, scale width, product width
  localparam int unsigned AW = 56;
  localparam int unsigned BW = 16;
  localparam int unsigned PW = AW + BW + 2;

  localparam int unsigned CLAMP_DEG = 360;

  typedef enum logic [MW-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_EVAL   = 2'd2
  } mode_e;

  // round(a * b / d), ties away from zero, d > 0
  typedef struct packed {
    logic                 start;
    logic signed [AW-1:0] a;
    logic [BW-1:0]        b;
    logic [BW-1:0]        d;
  } op_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [AW-1:0] res;
  } op_rsp_t;

  function automatic logic signed [AW-1:0] sext_y(input logic signed [YW-1:0] y);
    return {{(AW-YW){y[YW-1]}}, y};
  endfunction

endpackage

// ----- rtl/src_stream_if.sv -----
`timescale 1ns / 1ps

interface src_req_if
  import src_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MW-1:0]        mode;
  logic [XW-1:0]        point_x;
  logic signed [YW-1:0] point_y;
  logic signed [QW-1:0] query_x;

  modport source (output valid, mode, point_x, point_y, query_x, input ready);
  modport sink   (input valid, mode, point_x, point_y, query_x, output ready);
endinterface

interface src_rsp_if
  import src_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [YW-1:0] value;
  logic                 status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ----- rtl/src_muldiv.sv -----
`timescale 1ns / 1ps

module src_muldiv
  import src_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  op_req_t req_i,
  output op_rsp_t rsp_o
);

  localparam int unsigned CNTW = $clog2(PW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } st_e;

  st_e                  state_q;
  logic                 done_q;
  logic                 neg_q;
  logic [PW-1:0]        mcand_q;
  logic [BW:0]          mplr_q;
  logic [PW-1:0]        acc_q;
  logic [BW:0]          dvs_q;
  logic [BW:0]          rem_q;
  logic [CNTW-1:0]      cnt_q;
  logic signed [AW-1:0] res_q;

  logic [AW-1:0]        mag;
  logic [BW+1:0]        trial;
  logic                 qbit;
  logic [PW-1:0]        acc_d;
  logic [AW-1:0]        quo;

  assign mag   = req_i.a[AW-1] ? AW'(-req_i.a) : AW'(req_i.a);
  assign trial = {rem_q, acc_q[PW-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign acc_d = {acc_q[PW-2:0], qbit};
  assign quo   = acc_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            neg_q   <= req_i.a[AW-1];
            mcand_q <= PW'(mag);
            mplr_q  <= {req_i.b, 1'b0};
            acc_q   <= PW'(req_i.d);
            dvs_q   <= {req_i.d, 1'b0};
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        // shift-add over the doubled scale factor
        ST_MUL: begin
          if (mplr_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q <= {mcand_q[PW-2:0], 1'b0};
          mplr_q  <= {1'b0, mplr_q[BW:1]};
          if (cnt_q == CNTW'(BW)) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        // restoring division, one quotient bit a cycle
        ST_DIV: begin
          rem_q <= qbit ? (BW+1)'(trial - {1'b0, dvs_q}) : trial[BW:0];
          acc_q <= acc_d;
          if (cnt_q == CNTW'(PW - 1)) begin
            res_q   <= neg_q ? -$signed(quo) : $signed(quo);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (state_q != ST_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ----- rtl/spline_response_curve_core.sv -----
`timescale 1ns / 1ps

// channel  | dir | beat contents                         | handshake
// req_i    | in  | mode, point_x, point_y, query_x       | valid / ready
// rsp_o    | out | value, status                         | valid / ready
//
// one beat in, one beat out; a new beat is taken only once the previous
// result has left and the sequencer is back in idle
// clear completes straight from idle; insert moves each larger stored point
// up by one; evaluate: linear segment search one knot per read, up to four
// knot fetches, then up to five rounds of the shared multiply-divide unit
// (17 multiply steps, 74 divide steps each) and a final halving in place
// reset clears the knot count and the sequencer; knot storage is not cleared
// a stalled result is held in the output register and blocks new requests

module spline_response_curve_core
  import src_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned PRECISION  = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  src_req_if.sink     req_i,
  src_rsp_if.source   rsp_o
);

  localparam int unsigned IW          = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW          = $clog2(MAX_POINTS + 1);
  localparam int unsigned QUERY_LIMIT = CLAMP_DEG * PRECISION;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WAIT,
    S_INS,
    S_PUT,
    S_LAST,
    S_FIRST,
    S_SRCH,
    S_GA,
    S_GB,
    S_GC,
    S_GD,
    S_SEG,
    S_PA,
    S_PDS,
    S_PD,
    S_COEF,
    S_HS,
    S_HA,
    S_OPW,
    S_FIN
  } state_e;

  // knot storage, no reset: only entries below the count are read
  logic [XW-1:0]        knot_x_mem [MAX_POINTS];
  logic signed [YW-1:0] knot_y_mem [MAX_POINTS];

  state_e               state_q;
  state_e               ret_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        pos_q;
  logic [CW-1:0]        i_q;
  logic [1:0]           hstep_q;

  logic                 out_valid_q;
  logic signed [YW-1:0] value_q;
  logic                 status_q;

  logic [IW-1:0]        rd_addr_q;
  logic [XW-1:0]        rd_x_q;
  logic signed [YW-1:0] rd_y_q;
  logic                 we_q;
  logic [IW-1:0]        wr_addr_q;
  logic [XW-1:0]        wr_x_q;
  logic signed [YW-1:0] wr_y_q;

  logic [XW-1:0]        px_q;
  logic signed [YW-1:0] py_q;
  logic                 neg_q;
  logic [QW-1:0]        mag_q;
  logic [XW-1:0]        idx_q;

  logic [XW-1:0]        ax_q, bx_q, cx_q, dx_q;
  logic signed [YW-1:0] ay_q, by_q, cy_q, dy_q;
  logic [BW-1:0]        len_q;
  logic [BW-1:0]        u_q;
  logic signed [AW-1:0] pa_q, pd_q;
  logic signed [AW-1:0] y3_q, y2_q, y1_q;
  logic signed [AW-1:0] v_q;
  logic signed [AW-1:0] r_q;

  op_req_t              op_req_q;
  op_rsp_t              op_rsp;

  logic                 ready;
  logic                 accept;
  logic [QW-1:0]        q_mag;
  logic [QW-1:0]        q_clamped;
  logic [CW-1:0]        cnt_m1, i_p1, i_m1, i_m2, pos_m1, pos_m2, di;
  logic signed [AW-1:0] aby, aay, acy, ady, apa, apd;
  logic signed [AW-1:0] y4;
  logic signed [AW-1:0] y3;
  logic signed [AW-1:0] v_half;
  logic signed [AW-1:0] s_val;
  logic signed [YW-1:0] sat_val;

  assign ready  = (state_q == S_IDLE) && !out_valid_q;
  assign accept = req_i.valid && ready;

  assign req_i.ready  = ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.value  = value_q;
  assign rsp_o.status = status_q;

  // query magnitude, clamped to the full-scale angle
  assign q_mag     = req_i.query_x[QW-1] ? QW'(-req_i.query_x) : QW'(req_i.query_x);
  assign q_clamped = (int'(q_mag) > int'(QUERY_LIMIT)) ? QW'(QUERY_LIMIT) : q_mag;

  assign cnt_m1 = count_q - CW'(1);
  assign i_p1   = i_q + CW'(1);
  assign i_m1   = i_q - CW'(1);
  assign i_m2   = i_q - CW'(2);
  assign pos_m1 = pos_q - CW'(1);
  assign pos_m2 = pos_q - CW'(2);
  assign di     = (i_p1 < count_q) ? i_p1 : cnt_m1;

  // widened knot ordinates for the tangent and coefficient sums
  assign aby = sext_y(by_q);
  assign aay = sext_y(ay_q);
  assign acy = sext_y(cy_q);
  assign ady = sext_y(dy_q);
  assign apa = pa_q;
  assign apd = pd_q;

  // cubic coefficients, halved at the very end
  assign y4 = apd - (acy <<< 1) - acy + (aby <<< 1) + aby - apa;
  assign y3 = (acy <<< 2) - apd - (aby <<< 2) - aby + (apa <<< 1);

  // halving rounded half away from zero: floor for negatives, round up odd positives
  assign v_half = (v_q >>> 1) + $signed({{(AW-1){1'b0}}, v_q[0] & !v_q[AW-1]});

  // sign reapplied, then saturation to the output format
  assign s_val = neg_q ? -r_q : r_q;
  always_comb begin
    if (!s_val[AW-1] && (|s_val[AW-2:YW-1])) begin
      sat_val = {1'b0, {(YW-1){1'b1}}};
    end else if (s_val[AW-1] && !(&s_val[AW-2:YW-1])) begin
      sat_val = {1'b1, {(YW-1){1'b0}}};
    end else begin
      sat_val = s_val[YW-1:0];
    end
  end

  // knot memory: one registered read, one write a cycle
  always_ff @(posedge clk_i) begin
    if (we_q) begin
      knot_x_mem[wr_addr_q] <= wr_x_q;
      knot_y_mem[wr_addr_q] <= wr_y_q;
    end
    rd_x_q <= knot_x_mem[rd_addr_q];
    rd_y_q <= knot_y_mem[rd_addr_q];
  end

  // shared multiply-divide unit
  src_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (op_req_q),
    .rsp_o  (op_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ret_q          <= S_IDLE;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      we_q           <= 1'b0;
      op_req_q.start <= 1'b0;
    end else begin
      we_q           <= 1'b0;
      op_req_q.start <= 1'b0;
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            px_q     <= req_i.point_x;
            py_q     <= req_i.point_y;
            neg_q    <= req_i.query_x[QW-1];
            mag_q    <= q_clamped;
            value_q  <= '0;
            status_q <= 1'b0;
            unique case (mode_e'(req_i.mode))
              MODE_CLEAR: begin
                count_q     <= '0;
                out_valid_q <= 1'b1;
              end
              MODE_INSERT: begin
                pos_q <= count_q;
                if (count_q == CW'(MAX_POINTS)) begin
                  status_q    <= 1'b1;
                  out_valid_q <= 1'b1;
                end else if (count_q == '0) begin
                  state_q <= S_PUT;
                end else begin
                  rd_addr_q <= cnt_m1[IW-1:0];
                  ret_q     <= S_INS;
                  state_q   <= S_WAIT;
                end
              end
              MODE_EVAL: begin
                if (count_q == '0) begin
                  out_valid_q <= 1'b1;
                end else begin
                  rd_addr_q <= cnt_m1[IW-1:0];
                  ret_q     <= S_LAST;
                  state_q   <= S_WAIT;
                end
              end
              default: out_valid_q <= 1'b1;
            endcase
          end
        end

        // wait state for the registered memory read
        S_WAIT: state_q <= ret_q;

        // insertion sort step: move larger knots up by one
        S_INS: begin
          if (rd_x_q > px_q) begin
            we_q      <= 1'b1;
            wr_addr_q <= pos_q[IW-1:0];
            wr_x_q    <= rd_x_q;
            wr_y_q    <= rd_y_q;
            pos_q     <= pos_m1;
            if (pos_q == CW'(1)) begin
              state_q <= S_PUT;
            end else begin
              rd_addr_q <= pos_m2[IW-1:0];
              ret_q     <= S_INS;
              state_q   <= S_WAIT;
            end
          end else begin
            state_q <= S_PUT;
          end
        end

        S_PUT: begin
          we_q        <= 1'b1;
          wr_addr_q   <= pos_q[IW-1:0];
          wr_x_q      <= px_q;
          wr_y_q      <= py_q;
          count_q     <= count_q + CW'(1);
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end

        // last knot sets the curve span; beyond it the last sample holds
        S_LAST: begin
          if (rd_x_q == '0) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            idx_q     <= (mag_q < QW'(rd_x_q)) ? mag_q[XW-1:0] : rd_x_q - XW'(1);
            rd_addr_q <= '0;
            ret_q     <= S_FIRST;
            state_q   <= S_WAIT;
          end
        end

        // below the first knot: straight line from the origin
        S_FIRST: begin
          if (idx_q < rd_x_q) begin
            op_req_q.start <= 1'b1;
            op_req_q.a     <= sext_y(rd_y_q);
            op_req_q.b     <= idx_q;
            op_req_q.d     <= rd_x_q;
            hstep_q        <= 2'd3;
            ret_q          <= S_HA;
            state_q        <= S_OPW;
          end else begin
            i_q       <= CW'(1);
            rd_addr_q <= IW'(1);
            ret_q     <= S_SRCH;
            state_q   <= S_WAIT;
          end
        end

        // linear segment search, one knot per read
        S_SRCH: begin
          if ((i_q < cnt_m1) && (rd_x_q <= idx_q)) begin
            i_q       <= i_p1;
            rd_addr_q <= i_p1[IW-1:0];
            ret_q     <= S_SRCH;
          end else if (i_q >= CW'(2)) begin
            rd_addr_q <= i_m2[IW-1:0];
            ret_q     <= S_GA;
          end else begin
            ax_q      <= '0;
            ay_q      <= '0;
            rd_addr_q <= i_m1[IW-1:0];
            ret_q     <= S_GB;
          end
          state_q <= S_WAIT;
        end

        S_GA: begin
          ax_q      <= rd_x_q;
          ay_q      <= rd_y_q;
          rd_addr_q <= i_m1[IW-1:0];
          ret_q     <= S_GB;
          state_q   <= S_WAIT;
        end

        S_GB: begin
          bx_q      <= rd_x_q;
          by_q      <= rd_y_q;
          rd_addr_q <= i_q[IW-1:0];
          ret_q     <= S_GC;
          state_q   <= S_WAIT;
        end

        S_GC: begin
          cx_q      <= rd_x_q;
          cy_q      <= rd_y_q;
          rd_addr_q <= di[IW-1:0];
          ret_q     <= S_GD;
          state_q   <= S_WAIT;
        end

        S_GD: begin
          dx_q    <= rd_x_q;
          dy_q    <= rd_y_q;
          state_q <= S_SEG;
        end

        // zero-width segment takes the right knot; else scale left neighbour if distinct
        S_SEG: begin
          len_q <= cx_q - bx_q;
          u_q   <= idx_q - bx_q;
          if (cx_q == bx_q) begin
            r_q     <= acy;
            state_q <= S_FIN;
          end else if (bx_q == ax_q) begin
            pa_q    <= aby;
            state_q <= S_PDS;
          end else begin
            op_req_q.start <= 1'b1;
            op_req_q.a     <= aay - aby;
            op_req_q.b     <= cx_q - bx_q;
            op_req_q.d     <= bx_q - ax_q;
            ret_q          <= S_PA;
            state_q        <= S_OPW;
          end
        end

        S_PA: begin
          pa_q    <= aby + op_rsp.res;
          state_q <= S_PDS;
        end

        // right neighbour rescaled to the segment width, unless it coincides with the right knot
        S_PDS: begin
          if (dx_q == cx_q) begin
            pd_q    <= ady;
            state_q <= S_COEF;
          end else begin
            op_req_q.start <= 1'b1;
            op_req_q.a     <= ady - acy;
            op_req_q.b     <= len_q;
            op_req_q.d     <= dx_q - cx_q;
            ret_q          <= S_PD;
            state_q        <= S_OPW;
          end
        end

        S_PD: begin
          pd_q    <= acy + op_rsp.res;
          state_q <= S_COEF;
        end

        S_COEF: begin
          v_q     <= y4;
          y3_q    <= y3;
          y2_q    <= acy - apa;
          y1_q    <= aby <<< 1;
          hstep_q <= 2'd0;
          state_q <= S_HS;
        end

        // horner step: v * u / len, or the final halving in place
        S_HS: begin
          if (hstep_q == 2'd3) begin
            r_q     <= v_half;
            state_q <= S_FIN;
          end else begin
            op_req_q.start <= 1'b1;
            op_req_q.a     <= v_q;
            op_req_q.b     <= u_q;
            op_req_q.d     <= len_q;
            ret_q          <= S_HA;
            state_q        <= S_OPW;
          end
        end

        S_HA: begin
          unique case (hstep_q)
            2'd0: begin
              v_q     <= op_rsp.res + y3_q;
              state_q <= S_HS;
            end
            2'd1: begin
              v_q     <= op_rsp.res + y2_q;
              state_q <= S_HS;
            end
            2'd2: begin
              v_q     <= op_rsp.res + y1_q;
              state_q <= S_HS;
            end
            default: begin
              r_q     <= op_rsp.res;
              state_q <= S_FIN;
            end
          endcase
          hstep_q <= hstep_q + 2'd1;
        end

        S_OPW: begin
          if (op_rsp.done) begin
            state_q <= ret_q;
          end
        end

        S_FIN: begin
          value_q     <= sat_val;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // table never holds more points than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("knot count beyond table size");

  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !req_i.ready)
    else $error("request taken with result pending");

  // a refused insert carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.value == '0))
    else $error("refused insert with non-zero value");

  // shared unit is only started when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_req_q.start |-> !op_rsp.busy)
    else $error("multiply-divide started while busy");

  // a completed insert grows the table by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not advance the count");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import src_pkg::*;

  localparam int unsigned NPTS  = 16;
  localparam int unsigned PREC  = 100;
  localparam int          QLIM  = 360 * PREC;
  localparam int          WDOG  = 20000;
  localparam int          NRAND = 1750;

  typedef struct packed {
    logic [MW-1:0]        mode;
    logic [XW-1:0]        px;
    logic signed [YW-1:0] py;
    logic signed [QW-1:0] qx;
  } beat_t;

  typedef struct packed {
    logic signed [YW-1:0] value;
    logic                 status;
  } curve_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  src_req_if req_if ();
  src_rsp_if rsp_if ();

  spline_response_curve_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: mirrored point table
  logic [XW-1:0]        pt_x [NPTS];
  logic signed [YW-1:0] pt_y [NPTS];
  int unsigned          pt_n = 0;

  beat_t      pending_q [$];
  curve_rsp_t expected_q [$];
  int         errors = 0;
  bit         stim_done = 1'b0;
  bit         hold_rsp = 1'b0;
  int         idle_cycles = 0;

  function automatic longint rnd_div(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  // v * u / len rounded; widened to avoid overflow of v*2u
  function automatic longint t_scale(longint v, longint u, longint len);
    logic [127:0] mag;
    logic [127:0] q;
    mag = v < 0 ? 128'(-v) : 128'(v);
    q = (mag * 128'(2 * u) + 128'(len)) / 128'(2 * len);
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint curve_eval(int m);
    longint lastx, idx, ax, ay, bx, by, cx, cy, dx, dy, len, pa, pd;
    longint y4, y3, y2, y1, v, u;
    int i, di;
    if (pt_n == 0) return 0;
    lastx = pt_x[pt_n-1];
    if (lastx == 0) return 0;
    idx = m < lastx ? m : lastx - 1;
    if (idx < pt_x[0]) return rnd_div(longint'(pt_y[0]) * idx, longint'(pt_x[0]));
    i = 1;
    while (i < int'(pt_n) - 1 && longint'(pt_x[i]) <= idx) i++;
    ax = i >= 2 ? longint'(pt_x[i-2]) : 0;
    ay = i >= 2 ? longint'(pt_y[i-2]) : 0;
    bx = pt_x[i-1]; by = pt_y[i-1];
    cx = pt_x[i];   cy = pt_y[i];
    di = (i + 1 < int'(pt_n)) ? i + 1 : int'(pt_n) - 1;
    dx = pt_x[di];  dy = pt_y[di];
    len = cx - bx;
    if (len <= 0) return cy;
    u = idx - bx;
    pa = (bx == ax) ? by : by + rnd_div((ay - by) * len, bx - ax);
    pd = (dx == cx) ? dy : cy + rnd_div((dy - cy) * len, dx - cx);
    y4 = pd - 3 * cy + 3 * by - pa;
    y3 = -pd + 4 * cy - 5 * by + 2 * pa;
    y2 = cy - pa;
    y1 = 2 * by;
    v = t_scale(y4, u, len) + y3;
    v = t_scale(v, u, len) + y2;
    v = t_scale(v, u, len) + y1;
    return rnd_div(v, 2);
  endfunction

  function automatic curve_rsp_t predict_curve(beat_t b);
    curve_rsp_t r;
    int pos, mag;
    longint v;
    r = '0;
    case (b.mode)
      MODE_CLEAR: pt_n = 0;
      MODE_INSERT: begin
        if (pt_n >= NPTS) begin
          r.status = 1'b1;
        end else begin
          pos = pt_n;
          while (pos > 0 && pt_x[pos-1] > b.px) begin
            pt_x[pos] = pt_x[pos-1];
            pt_y[pos] = pt_y[pos-1];
            pos--;
          end
          pt_x[pos] = b.px;
          pt_y[pos] = b.py;
          pt_n++;
        end
      end
      MODE_EVAL: begin
        mag = b.qx < 0 ? -int'(b.qx) : int'(b.qx);
        if (mag > QLIM) mag = QLIM;
        v = curve_eval(mag);
        if (b.qx < 0) v = -v;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.value = v[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic beat_t mk(logic [MW-1:0] md, int x, int y, int q);
    beat_t b;
    b.mode = md; b.px = x[XW-1:0]; b.py = y; b.qx = q[QW-1:0];
    return b;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= MODE_CLEAR;
      req_if.point_x <= '0;
      req_if.point_y <= '0;
      req_if.query_x <= '0;
      gap = 0;
    end else if (req_if.valid && !req_if.ready) begin
      // hold the offered beat
    end else begin
      if (req_if.valid) expected_q.push_back(predict_curve(
          mk(req_if.mode, req_if.point_x, req_if.point_y, req_if.query_x)));
      if (gap > 0) begin
        gap--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0 && pending_q[0].mode == 2'd3) begin
        // marker: wait until every expected result has arrived
        req_if.valid <= 1'b0;
        if (expected_q.size() == 0 && !req_if.valid) void'(pending_q.pop_front());
      end else if (pending_q.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.mode <= pending_q[0].mode;
        req_if.point_x <= pending_q[0].px;
        req_if.point_y <= pending_q[0].py;
        req_if.query_x <= pending_q[0].qx;
        void'(pending_q.pop_front());
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(11);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int stall = 0;
  curve_rsp_t got, exp_r;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.value = rsp_if.value;
        got.status = rsp_if.status;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   got.value, got.status);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.value !== exp_r.value)
            begin
              $display("%0t: value mismatch expected %0d actual %0d", $time,
                       exp_r.value, got.value);
              errors++;
            end
          if (got.status !== exp_r.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time,
                     exp_r.status, got.status);
            errors++;
          end
        end
        stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(11);
      end
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || hold_rsp)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("spline_response_curve_core test failed");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    repeat (3000) @(posedge clk_i);
    hold_rsp = 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_rsp = 1'b0;
  end

  task automatic add_table(int n, bit rand_y);
    int k;
    for (k = 0; k < n; k++)
      pending_q.push_back(mk(MODE_INSERT, $urandom_range(QLIM + 500, 1),
        rand_y ? int'($urandom) : int'($urandom_range(400 << 16)), 0));
  endtask

  task automatic add_queries(int n);
    int k, q;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(5))
        0: q = $urandom_range(36000) - 36000 + 2 * $urandom_range(36000);
        1: q = $urandom_range(65535) - 65536;  // all negative bit patterns, clamped
        2: q = $urandom_range(65535);
        default: q = int'($urandom_range(72000)) - 36000;
      endcase
      pending_q.push_back(mk(MODE_EVAL, 0, 0, q));
    end
  endtask

  initial begin
    int k, total;
    beat_t pause_b;
    pause_b = '0;
    pause_b.mode = 2'd3;
    // directed: empty table, extremes, full table, equal abscissae
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 36000));
    pending_q.push_back(mk(MODE_INSERT, 0, 5 << 16, 0));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 100));        // last x zero
    pending_q.push_back(mk(MODE_INSERT, 65535, 32'sh7fffffff, 0));
    pending_q.push_back(mk(MODE_INSERT, 3000, 32'sh80000000, 0));
    pending_q.push_back(mk(MODE_INSERT, 3000, 90 << 16, 0)); // equal x
    pending_q.push_back(mk(MODE_INSERT, 1000, -(20 << 16), 0));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 0));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 500));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 2999));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, -36000));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, -65536));
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 65535));
    pending_q.push_back(pause_b);
    for (k = 0; k < 13; k++) pending_q.push_back(mk(MODE_INSERT, 40000 + k, k, 0));
    pending_q.push_back(mk(MODE_INSERT, 1, 1, 0));        // refused, full
    pending_q.push_back(mk(MODE_EVAL, 0, 0, 36000));
    pending_q.push_back(mk(MODE_CLEAR, 0, 0, 0));
    total = 0;
    while (total < NRAND) begin
      pending_q.push_back(mk(MODE_CLEAR, $urandom, $urandom, $urandom));
      k = $urandom_range(NPTS + 2);
      add_table(k, $urandom_range(1));
      add_queries(8);
      total += k + 9;
      if ($urandom_range(7) == 0) pending_q.push_back(pause_b);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    stim_done = 1'b1;
    wait (expected_q.size() == 0 && !req_if.valid);
    repeat (700) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("spline_response_curve_core test passed");
    else
      $display("spline_response_curve_core test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/src_pkg.sv
rtl/src_stream_if.sv
rtl/src_muldiv.sv
rtl/spline_response_curve_core.sv
dv/tb.sv
